### rtl/sce_pkg.sv
// Shared types, widths and constants for the softmax cross-entropy block.
// Holds the exp coefficient table builder used by the exp unit.
// No dependencies.
`timescale 1ns / 1ps

package sce_pkg;

	localparam int MAX_CLASSES_DEF = 64;
	localparam int EXP_BITS_DEF    = 10;
	localparam int EXP_BITS_MAX    = 14;

	localparam int LOGIT_W = 24;
	localparam int VAL_W   = 40;
	localparam int CLS_W   = 6;
	localparam int ROWS_W  = 16;
	localparam int DY_W    = 32;
	localparam int E_W     = 17;
	localparam int S_W     = 23;
	localparam int T_W     = 29;
	localparam int LNS_W   = 20;
	localparam int LOSS_W  = 56;
	localparam int DIVN_W  = 57;
	localparam int LN_STEPS = 16;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_BATCH = 2'd1;
	localparam logic [1:0] REG_DY    = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NEG_LABEL = 2'd1,
		STAT_ZERO_MASS = 2'd2,
		STAT_ROW_LONG  = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,
		ST_MAX_RD,
		ST_MAX_CMP,
		ST_EXP_RD,
		ST_EXP_GO,
		ST_EXP_WAIT,
		ST_CHECK,
		ST_LN_WAIT,
		ST_ACC_RD,
		ST_ACC_MUL,
		ST_ACC_ADD,
		ST_ACC_FIN,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MEAN_OUT,
		ST_G_RD,
		ST_G_MUL,
		ST_G_DIV,
		ST_G_DIV_WAIT,
		ST_G_D,
		ST_G_SCALE,
		ST_G_DIV2_WAIT,
		ST_G_OUT
	} state_t;

	typedef logic [EXP_BITS_MAX:1][31:0] exp_coef_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = v;
		r   = '0;
		for (int k = 0; k < 32; k++) begin
			b = 64'd1 << (62 - 2 * k);
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// c(i) = isqrt(c(i-1) << 32), c(0) = 2^31: 2^32 * 2^(-2^-i)
	function automatic exp_coef_t coef_table();
		exp_coef_t   tab;
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int i = 1; i <= EXP_BITS_MAX; i++) begin
			c      = isqrt64(c << 32);
			tab[i] = c[31:0];
		end
		return tab;
	endfunction

endpackage

### rtl/sce_exp.sv
// Iterative exp(-t) unit: t in Q.16, result in Q1.16.
// One coefficient multiply per cycle; uses sce_pkg.
`timescale 1ns / 1ps

module sce_exp import sce_pkg::*; #(
	parameter int EXP_TABLE_BITS = EXP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [LOGIT_W-1:0]  t,
	output logic                done,
	output logic [E_W-1:0]      e
);

	localparam int SW = $clog2(EXP_TABLE_BITS + 2);
	localparam logic [SW-1:0] LAST = SW'(EXP_TABLE_BITS + 1);
	localparam exp_coef_t COEF = coef_table();

	logic              busy_q;
	logic              done_q;
	logic [SW-1:0]     step_q;
	logic [LOGIT_W-1:0] t_q;
	logic [24:0]       u_q;
	logic [32:0]       m_q;
	logic [E_W-1:0]    e_q;

	logic [54:0] u_prod;
	logic [31:0] coef;
	logic [64:0] m_prod;
	logic        f_bit;
	logic [8:0]  k;
	logic [33:0] rnd_sum;
	logic [33:0] rnd_shr;

	always_comb begin
		u_prod  = 55'(t_q) * 55'(LOG2E_Q30);
		coef    = (step_q == '0) ? COEF[1] : COEF[step_q];
		m_prod  = 65'(m_q) * 65'(coef);
		f_bit   = u_q[5'd16 - 5'(step_q)];
		k       = u_q[24:16];
		rnd_sum = 34'(m_q) + (34'd1 << (6'd15 + 6'(k[4:0])));
		rnd_shr = rnd_sum >> (6'd16 + 6'(k[4:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t;
		end else if (busy_q) begin
			if (step_q == '0) begin
				u_q <= u_prod[54:30];
				m_q <= 33'h1_0000_0000;
			end else if (step_q == LAST) begin
				// too far below the max: rounds to zero
				e_q <= (k > 9'd16) ? '0 : rnd_shr[E_W-1:0];
			end else if (f_bit) begin
				m_q <= m_prod[64:32];
			end
		end
	end

	assign done = done_q;
	assign e    = e_q;

endmodule

### rtl/sce_ln.sv
// Iterative natural log of the row sum, Q.16 result.
// One squaring step per cycle; uses sce_pkg.
`timescale 1ns / 1ps

module sce_ln import sce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [S_W-1:0]   s,
	output logic             done,
	output logic [LNS_W-1:0] lns
);

	localparam logic [4:0] LAST = 5'(LN_STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [4:0]       step_q;
	logic [S_W-1:0]   s_q;
	logic [2:0]       n_q;
	logic [30:0]      y_q;
	logic [15:0]      frac_q;
	logic [LNS_W-1:0] lns_q;

	logic [2:0]  n_c;
	logic [36:0] y_init;
	logic [61:0] sq;
	logic [49:0] l2_prod;

	always_comb begin
		n_c = '0;
		for (int i = 1; i <= 6; i++) begin
			if (s_q[16 + i]) n_c = 3'(i);
		end
		y_init  = ({14'd0, s_q} << 14) >> n_c;
		sq      = 62'(y_q) * 62'(y_q);
		l2_prod = 50'({n_q, frac_q}) * 50'(LN2_Q30) + (50'd1 << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= s;
		end else if (busy_q) begin
			if (step_q == '0) begin
				n_q    <= n_c;
				y_q    <= y_init[30:0];
				frac_q <= '0;
			end else if (step_q == LAST) begin
				lns_q <= l2_prod[49:30];
			end else if (sq[61]) begin
				// square reached 2.0: halve, emit a one
				y_q    <= sq[61:31];
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				y_q    <= sq[60:30];
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign lns  = lns_q;

endmodule

### rtl/sce_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the mean, probability and gradient scaling; uses sce_pkg.
`timescale 1ns / 1ps

module sce_div import sce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [S_W-1:0]    divisor,
	output logic              done,
	output logic [DIVN_W-1:0] quotient
);

	localparam int CW = $clog2(DIVN_W);
	localparam logic [CW-1:0] LAST = CW'(DIVN_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVN_W-1:0] qr_q;
	logic [S_W-1:0]    rem_q;
	logic [S_W-1:0]    dvs_q;

	logic [S_W:0] trial;
	logic         fits;
	logic [S_W:0] diff;

	always_comb begin
		trial = {rem_q, qr_q[DIVN_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[S_W-1:0] : trial[S_W-1:0];
			qr_q  <= {qr_q[DIVN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = qr_q;

endmodule

### rtl/softmax_cross_entropy_loss_grad.sv
// Softmax cross-entropy loss and gradient over rows of up to MAX_CLASSES classes.
// Loading accepts items only while idle. At a row end: a max pass over the classes,
// an exp pass (iterative exp unit), then for loss a log of the row sum and an accumulate
// pass, and a mean when a batch closes; for the gradient, each class takes two 57-bit
// divisions on the shared divider. Results leave through a one-word register.
// Async reset clears control, counters and loss total; buffer memories are not cleared.
`timescale 1ns / 1ps

module softmax_cross_entropy_loss_grad import sce_pkg::*; #(
	parameter int MAX_CLASSES    = MAX_CLASSES_DEF,
	parameter int EXP_TABLE_BITS = EXP_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [DY_W-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [LOGIT_W-1:0]  logit,
	input  logic [LOGIT_W-1:0]  label,
	input  logic                row_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VAL_W-1:0]    value,
	output logic [CLS_W-1:0]    class_index,
	output logic [1:0]          status,
	output logic                last
);

	localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int FW = $clog2(MAX_CLASSES + 1);

	state_t state_q, state_d;

	logic                  mode_q;
	logic [ROWS_W-1:0]     batch_q;
	logic signed [DY_W-1:0] dy_q;
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         j_q;
	status_t               err_q;
	logic [ROWS_W-1:0]     rows_done_q;
	logic [LOSS_W-1:0]     loss_q;

	logic                  out_valid_q;
	logic [VAL_W-1:0]      value_q;
	logic [CLS_W-1:0]      cls_q;
	logic [1:0]            status_q;
	logic                  last_q;

	logic [2*LOGIT_W-1:0]  mem_a [MAX_CLASSES];
	logic [E_W-1:0]        mem_e [MAX_CLASSES];
	logic [2*LOGIT_W-1:0]  rd_a_q;
	logic [E_W-1:0]        rd_e_q;

	logic signed [LOGIT_W-1:0] mx_q;
	logic [T_W-1:0]        tsum_q;
	logic [S_W-1:0]        ssum_q;
	logic [LNS_W-1:0]      lns_q;
	logic [LOSS_W-1:0]     acc_q;
	logic [47:0]           prod_q;
	logic [45:0]           gnum_q;
	logic [LOGIT_W-1:0]    lab_q;
	logic [60:0]           mag_q;
	logic                  neg_q;

	logic                  in_fire;
	logic                  cfg_fire;
	logic                  full;
	status_t               err_ovf;
	status_t               err_new;
	logic                  slot_free;
	logic                  j_last;
	logic [ROWS_W-1:0]     rows16;
	logic signed [LOGIT_W-1:0] rd_x;
	logic [LOGIT_W-1:0]    rd_l;
	logic [LOGIT_W:0]      diff;
	logic signed [29:0]    d_s;
	logic [29:0]           d_neg;
	logic [28:0]           d_abs;
	logic [DY_W-1:0]       dy_mag;
	logic [61:0]           sc_sum;
	logic [LOSS_W:0]       acc_rnd;
	logic                  q_big;

	logic                  out_load;
	logic [VAL_W-1:0]      res_value;
	logic [CLS_W-1:0]      res_cls;
	logic [1:0]            res_status;
	logic                  res_last;

	logic                  exp_start, exp_done;
	logic [E_W-1:0]        exp_e;
	logic                  ln_start, ln_done;
	logic [LNS_W-1:0]      ln_out;
	logic                  div_start, div_done;
	logic [DIVN_W-1:0]     div_n, div_q;
	logic [S_W-1:0]        div_d;

	sce_exp #(
		.EXP_TABLE_BITS(EXP_TABLE_BITS)
	) u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.t      (diff[LOGIT_W-1:0]),
		.done   (exp_done),
		.e      (exp_e)
	);

	sce_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.s      (ssum_q),
		.done   (ln_done),
		.lns    (ln_out)
	);

	sce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		in_fire   = in_valid && in_ready;
		cfg_fire  = cfg_valid && cfg_ready;
		full      = (fill_q == FW'(MAX_CLASSES));
		err_ovf   = (err_q != STAT_OK) ? err_q : (full ? STAT_ROW_LONG : STAT_OK);
		err_new   = (err_ovf != STAT_OK) ? err_ovf :
			(label[LOGIT_W-1] ? STAT_NEG_LABEL : STAT_OK);
		slot_free = !out_valid_q || out_ready;
		j_last    = ((j_q + 1'b1) == fill_q);
		rows16    = (batch_q == '0) ? ROWS_W'(1) : batch_q;
		rd_x      = $signed(rd_a_q[2*LOGIT_W-1:LOGIT_W]);
		rd_l      = rd_a_q[LOGIT_W-1:0];
		diff      = {mx_q[LOGIT_W-1], mx_q} - {rd_x[LOGIT_W-1], rd_x};
		d_s       = $signed({1'b0, div_q[28:0]}) - $signed({6'd0, lab_q});
		d_neg     = -d_s;
		d_abs     = d_s[29] ? d_neg[28:0] : d_s[28:0];
		dy_mag    = dy_q[DY_W-1] ? (~dy_q + 1'b1) : dy_q;
		sc_sum    = 62'(mag_q) + (62'(rows16) << 15);
		acc_rnd   = {1'b0, acc_q} + (LOSS_W+1)'(16'h8000);
		q_big     = (div_q[DIVN_W-1:VAL_W-1] != '0);
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		exp_start  = 1'b0;
		ln_start   = 1'b0;
		div_start  = 1'b0;
		div_n      = '0;
		div_d      = '0;
		out_load   = 1'b0;
		res_value  = '0;
		res_cls    = '0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire && row_end) begin
					state_d = (err_new != STAT_OK) ? ST_ERR : ST_MAX_RD;
				end
			end
			ST_ERR: begin
				res_status = err_q;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_MAX_RD:   state_d = ST_MAX_CMP;
			ST_MAX_CMP:  state_d = j_last ? ST_EXP_RD : ST_MAX_RD;
			ST_EXP_RD:   state_d = ST_EXP_GO;
			ST_EXP_GO: begin
				exp_start = 1'b1;
				state_d   = ST_EXP_WAIT;
			end
			ST_EXP_WAIT: begin
				if (exp_done) state_d = j_last ? ST_CHECK : ST_EXP_RD;
			end
			ST_CHECK: begin
				if (mode_q && tsum_q == '0) begin
					state_d = ST_ERR;
				end else if (mode_q) begin
					state_d = ST_G_RD;
				end else begin
					ln_start = 1'b1;
					state_d  = ST_LN_WAIT;
				end
			end
			ST_LN_WAIT: begin
				if (ln_done) state_d = ST_ACC_RD;
			end
			ST_ACC_RD:   state_d = ST_ACC_MUL;
			ST_ACC_MUL:  state_d = ST_ACC_ADD;
			ST_ACC_ADD:  state_d = j_last ? ST_ACC_FIN : ST_ACC_RD;
			ST_ACC_FIN:  state_d = ST_MEAN_GO;
			ST_MEAN_GO: begin
				if (rows_done_q != '0) begin
					state_d = ST_IDLE;
				end else begin
					div_start = 1'b1;
					div_n     = DIVN_W'(loss_q) + DIVN_W'(rows16 >> 1);
					div_d     = S_W'(rows16);
					state_d   = ST_MEAN_WAIT;
				end
			end
			ST_MEAN_WAIT: begin
				if (div_done) state_d = ST_MEAN_OUT;
			end
			ST_MEAN_OUT: begin
				res_value = q_big ? VAL_MAX : div_q[VAL_W-1:0];
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_G_RD:  state_d = ST_G_MUL;
			ST_G_MUL: state_d = ST_G_DIV;
			ST_G_DIV: begin
				div_start = 1'b1;
				div_n     = DIVN_W'(gnum_q);
				div_d     = ssum_q;
				state_d   = ST_G_DIV_WAIT;
			end
			ST_G_DIV_WAIT: begin
				if (div_done) state_d = ST_G_D;
			end
			ST_G_D: state_d = ST_G_SCALE;
			ST_G_SCALE: begin
				div_start = 1'b1;
				div_n     = DIVN_W'(sc_sum[61:16]);
				div_d     = S_W'(rows16);
				state_d   = ST_G_DIV2_WAIT;
			end
			ST_G_DIV2_WAIT: begin
				if (div_done) state_d = ST_G_OUT;
			end
			ST_G_OUT: begin
				res_cls  = CLS_W'(j_q);
				res_last = j_last;
				if (neg_q) begin
					res_value = q_big ? VAL_MIN : (~div_q[VAL_W-1:0] + 1'b1);
				end else begin
					res_value = q_big ? VAL_MAX : div_q[VAL_W-1:0];
				end
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = j_last ? ST_IDLE : ST_G_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			batch_q     <= ROWS_W'(1);
			dy_q        <= DY_W'(65536);
			fill_q      <= '0;
			j_q         <= '0;
			err_q       <= STAT_OK;
			rows_done_q <= '0;
			loss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[0];
					REG_BATCH: batch_q <= cfg_data[ROWS_W-1:0];
					REG_DY:    dy_q    <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!full) fill_q <= fill_q + 1'b1;
						err_q <= err_new;
					end
				end
				ST_ERR: begin
					if (slot_free) begin
						rows_done_q <= '0;
						loss_q      <= '0;
					end
				end
				ST_MAX_CMP, ST_ACC_ADD: j_q <= j_last ? '0 : j_q + 1'b1;
				ST_EXP_WAIT: begin
					if (exp_done) j_q <= j_last ? '0 : j_q + 1'b1;
				end
				ST_CHECK: begin
					if (mode_q && tsum_q == '0) begin
						err_q <= STAT_ZERO_MASS;
					end else if ((17'(rows_done_q) + 17'd1) >= 17'(rows16)) begin
						rows_done_q <= '0;
					end else begin
						rows_done_q <= rows_done_q + 1'b1;
					end
				end
				ST_ACC_FIN: loss_q <= loss_q + LOSS_W'(acc_rnd[LOSS_W:16]);
				ST_MEAN_OUT: begin
					if (slot_free) loss_q <= '0;
				end
				ST_G_OUT: begin
					if (slot_free) j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
			// drop row state on the way back to idle
			if (state_d == ST_IDLE && state_q != ST_IDLE) begin
				fill_q <= '0;
				j_q    <= '0;
				err_q  <= STAT_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && !full) begin
			mem_a[fill_q[AW-1:0]] <= {logit, label};
		end
		if (state_q == ST_EXP_WAIT && exp_done) begin
			mem_e[j_q[AW-1:0]] <= exp_e;
		end
		rd_a_q <= mem_a[j_q[AW-1:0]];
		rd_e_q <= mem_e[j_q[AW-1:0]];

		case (state_q)
			ST_MAX_CMP: begin
				if (j_q == '0 || rd_x > mx_q) mx_q <= rd_x;
			end
			ST_EXP_GO: begin
				tsum_q <= ((j_q == '0) ? '0 : tsum_q) + T_W'(rd_l[LOGIT_W-2:0]);
			end
			ST_EXP_WAIT: begin
				if (exp_done) ssum_q <= ((j_q == '0) ? '0 : ssum_q) + S_W'(exp_e);
			end
			ST_LN_WAIT: begin
				if (ln_done) begin
					lns_q <= ln_out;
					acc_q <= '0;
				end
			end
			ST_ACC_MUL: begin
				prod_q <= 48'(rd_l[LOGIT_W-2:0]) *
					48'(25'(diff[LOGIT_W-1:0]) + 25'(lns_q));
			end
			ST_ACC_ADD: acc_q <= acc_q + LOSS_W'(prod_q);
			ST_G_MUL: begin
				gnum_q <= 46'(rd_e_q) * 46'(tsum_q) + 46'(ssum_q >> 1);
				lab_q  <= rd_l;
			end
			ST_G_D: begin
				mag_q <= 61'(dy_mag) * 61'(d_abs);
				neg_q <= d_s[29] ^ dy_q[DY_W-1];
			end
			default: ;
		endcase

		if (out_load) begin
			value_q  <= res_value;
			cls_q    <= res_cls;
			status_q <= res_status;
			last_q   <= res_last;
		end
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign class_index = cls_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule
